@@ design/cpc_pkg.sv @@
package cpc_pkg;

   localparam int COEF_W  = 32;
   localparam int GAMMA_W = 48;
   localparam int IDX_W   = 3;
   localparam int TCOEF_W = 12;
   localparam int PROD_W  = GAMMA_W + TCOEF_W;
   localparam int SUM_W   = PROD_W + 1;

   localparam logic [IDX_W-1:0] DEGREE_RESET  = 3'd7;
   localparam logic [IDX_W-1:0] DEGREE_FLOOR  = 3'd1;
   localparam logic [IDX_W-1:0] FIRST_REC_DEG = 3'd2;

   localparam logic signed [GAMMA_W-1:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [GAMMA_W-1:0] Q48_MIN = -48'sh8000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ACC_MUL,
      ST_ACC_ADD,
      ST_GAM_MUL,
      ST_GAM_OUT
   } seq_state_type;

   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] load_idx;
      logic             init;
      logic             acc_sel;
      logic             mul_go;
      logic             acc_wr;
      logic             gam_wr;
      logic             last;
      logic [IDX_W-1:0] k;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
   } cpc_ctrl_type;

   // Coefficient of x^i in the Chebyshev polynomial T_k.
   function automatic logic signed [TCOEF_W-1:0] cheb_coef(input logic [IDX_W-1:0] k,
                                                          input logic [IDX_W-1:0] i);
      logic signed [TCOEF_W-1:0] v;
      v = '0;
      case ({k, i})
         6'o00: v = 12'sd1;
         6'o11: v = 12'sd1;
         6'o20: v = -12'sd1;
         6'o22: v = 12'sd2;
         6'o31: v = -12'sd3;
         6'o33: v = 12'sd4;
         6'o40: v = 12'sd1;
         6'o42: v = -12'sd8;
         6'o44: v = 12'sd8;
         6'o51: v = 12'sd5;
         6'o53: v = -12'sd20;
         6'o55: v = 12'sd16;
         6'o60: v = -12'sd1;
         6'o62: v = 12'sd18;
         6'o64: v = -12'sd48;
         6'o66: v = 12'sd32;
         6'o71: v = -12'sd7;
         6'o73: v = 12'sd56;
         6'o75: v = -12'sd112;
         6'o77: v = 12'sd64;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Binomial coefficient C(i, j) for j from 0 to i.
   function automatic logic signed [TCOEF_W-1:0] binom(input logic [IDX_W-1:0] i,
                                                      input logic [IDX_W-1:0] j);
      logic signed [TCOEF_W-1:0] v;
      v = 12'sd1;
      case ({i, j})
         6'o21: v = 12'sd2;
         6'o31: v = 12'sd3;
         6'o32: v = 12'sd3;
         6'o41: v = 12'sd4;
         6'o42: v = 12'sd6;
         6'o43: v = 12'sd4;
         6'o51: v = 12'sd5;
         6'o52: v = 12'sd10;
         6'o53: v = 12'sd10;
         6'o54: v = 12'sd5;
         6'o61: v = 12'sd6;
         6'o62: v = 12'sd15;
         6'o63: v = 12'sd20;
         6'o64: v = 12'sd15;
         6'o65: v = 12'sd6;
         6'o71: v = 12'sd7;
         6'o72: v = 12'sd21;
         6'o73: v = 12'sd35;
         6'o74: v = 12'sd35;
         6'o75: v = 12'sd21;
         6'o76: v = 12'sd7;
         default: v = 12'sd1;
      endcase
      return v;
   endfunction

endpackage

@@ design/cpc_mac.sv @@
module cpc_mac
   import cpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      mul_go,
   input  logic signed [GAMMA_W-1:0] mul_a,
   input  logic signed [TCOEF_W-1:0] mul_b,
   input  logic                      sym_clamp,
   input  logic signed [GAMMA_W-1:0] addend,
   output logic signed [GAMMA_W-1:0] result,
   output logic                      sat
);

   localparam logic signed [SUM_W-1:0] SumMax    = SUM_W'(Q48_MAX);
   localparam logic signed [SUM_W-1:0] SumMin    = SUM_W'(Q48_MIN);
   localparam logic signed [SUM_W-1:0] SumMinSym = -SUM_W'(Q48_MAX);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     sym_ff;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  low;

   always_ff @(posedge clock) begin
      if (mul_go) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
         sym_ff  <= sym_clamp;
      end
   end

   // A negated term is clamped symmetrically, which matches clamping
   // the plain product first and then negating it with saturation.
   always_comb begin
      sum = SUM_W'(prod_ff) + SUM_W'(addend);
      low = sym_ff ? SumMinSym : SumMin;
      if (sum > SumMax) begin
         result = Q48_MAX;
         sat    = 1'b1;
      end else if (sum < low) begin
         result = GAMMA_W'(low);
         sat    = 1'b1;
      end else begin
         result = sum[GAMMA_W-1:0];
         sat    = 1'b0;
      end
   end

endmodule

@@ design/cpc_seq.sv @@
module cpc_seq
   import cpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             csr_write,
   input  logic             out_free,
   input  logic [IDX_W-1:0] used_deg,
   output cpc_ctrl_type     ctrl
);

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      req_ready     = 1'b0;
      ctrl          = '0;
      ctrl.load_idx = count_ff;
      ctrl.k        = k_ff;
      ctrl.i        = i_ff;
      ctrl.j        = j_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               if (count_ff == used_deg) begin
                  count_in = '0;
                  state_in = ST_INIT;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
         end
         ST_INIT: begin
            ctrl.init = 1'b1;
            k_in      = FIRST_REC_DEG;
            i_in      = '0;
            j_in      = '0;
            state_in  = (used_deg == DEGREE_FLOOR) ? ST_GAM_MUL : ST_ACC_MUL;
         end
         ST_ACC_MUL: begin
            ctrl.acc_sel = 1'b1;
            ctrl.mul_go  = 1'b1;
            state_in     = ST_ACC_ADD;
         end
         ST_ACC_ADD: begin
            ctrl.acc_sel = 1'b1;
            ctrl.acc_wr  = 1'b1;
            state_in     = ST_ACC_MUL;
            if (i_ff == k_ff) begin
               i_in = '0;
               if (k_ff == used_deg) begin
                  j_in     = '0;
                  state_in = ST_GAM_MUL;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end else begin
               i_in = i_ff + 3'd1;
            end
         end
         ST_GAM_MUL: begin
            ctrl.mul_go = 1'b1;
            state_in    = ST_GAM_OUT;
         end
         ST_GAM_OUT: begin
            ctrl.last = (i_ff == used_deg) && (j_ff == i_ff);
            if (out_free) begin
               ctrl.gam_wr = 1'b1;
               state_in    = ST_GAM_MUL;
               if (j_ff == i_ff) begin
                  j_in = '0;
                  if (i_ff == used_deg) begin
                     i_in     = '0;
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + 3'd1;
                  end
               end else begin
                  j_in = j_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         count_in = '0;
      end
   end

endmodule

@@ design/chebyshev_to_power_conversion.sv @@
// Loads degree+1 Chebyshev coefficients (signed Q8.24), one per req transfer, and
// after the last one emits the (d+1)(d+2)/2 gamma terms c_i*C(i,j)*(-1)^(i-j) in
// Q24.24, ordered by i then j, with last_term on the final one; d is the degree
// register clamped to 1..min(MAX_DEGREE,7). One shared multiply-and-saturate unit
// does all arithmetic under a small sequencer, as a registered multiply followed
// by a saturating add: after the last coefficient a setup state copies the first
// two coefficients into the accumulators, then multiply and add states form the
// power coefficients, then a multiply and an output state emit each term, holding
// while rsp is stalled. The block takes no req transfer until the final term is in
// the output register. A degree write restarts loading at coefficient zero.
module chebyshev_to_power_conversion
   import cpc_pkg::*;
#(
   parameter int MAX_DEGREE = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COEF_W-1:0]  req_cheb_coeff,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [GAMMA_W-1:0] rsp_gamma_value,
   output logic [IDX_W-1:0]          rsp_power_index,
   output logic [IDX_W-1:0]          rsp_term_index,
   output logic                      rsp_overflow,
   output logic                      rsp_last_term,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [IDX_W-1:0]          csr_degree
);

   localparam int UsedMax = (MAX_DEGREE > 7) ? 7 : MAX_DEGREE;
   localparam int Depth   = UsedMax + 1;
   localparam int AddrW   = $clog2(Depth);

   localparam logic [IDX_W-1:0] MaxDeg = IDX_W'(UsedMax);

   logic [IDX_W-1:0]          degree_ff;
   logic [IDX_W-1:0]          used_deg;
   logic signed [COEF_W-1:0]  store_ff [Depth];
   logic signed [GAMMA_W-1:0] accum_ff [Depth];
   logic                      ovf_ff   [Depth];

   cpc_ctrl_type              ctrl;
   logic                      out_free;
   logic [AddrW-1:0]          ka;
   logic [AddrW-1:0]          ia;
   logic                      neg;
   logic signed [TCOEF_W-1:0] nck;
   logic signed [GAMMA_W-1:0] mul_a;
   logic signed [TCOEF_W-1:0] mul_b;
   logic signed [GAMMA_W-1:0] addend;
   logic signed [GAMMA_W-1:0] mac_result;
   logic                      mac_sat;

   logic                      rsp_valid_ff;
   logic signed [GAMMA_W-1:0] rsp_gamma_ff;
   logic [IDX_W-1:0]          rsp_power_ff;
   logic [IDX_W-1:0]          rsp_term_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
      end else if (csr_valid) begin
         degree_ff <= csr_degree;
      end
   end

   always_comb begin
      if (degree_ff < DEGREE_FLOOR) begin
         used_deg = DEGREE_FLOOR;
      end else if (degree_ff > MaxDeg) begin
         used_deg = MaxDeg;
      end else begin
         used_deg = degree_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   cpc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_write (csr_valid),
      .out_free  (out_free),
      .used_deg  (used_deg),
      .ctrl      (ctrl)
   );

   assign ka  = ctrl.k[AddrW-1:0];
   assign ia  = ctrl.i[AddrW-1:0];
   assign neg = ctrl.i[0] ^ ctrl.j[0];
   assign nck = binom(ctrl.i, ctrl.j);

   always_comb begin
      if (ctrl.acc_sel) begin
         mul_a  = GAMMA_W'(store_ff[ka]);
         mul_b  = cheb_coef(ctrl.k, ctrl.i);
         addend = accum_ff[ia];
      end else begin
         mul_a  = accum_ff[ia];
         mul_b  = neg ? -nck : nck;
         addend = '0;
      end
   end

   cpc_mac u_mac (
      .clock     (clock),
      .mul_go    (ctrl.mul_go),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .sym_clamp (!ctrl.acc_sel && neg),
      .addend    (addend),
      .result    (mac_result),
      .sat       (mac_sat)
   );

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         store_ff[ctrl.load_idx[AddrW-1:0]] <= req_cheb_coeff;
      end
      if (ctrl.init) begin
         for (int e = 0; e < Depth; e++) begin
            ovf_ff[e] <= 1'b0;
            if (e < 2) begin
               accum_ff[e] <= GAMMA_W'(store_ff[e]);
            end else begin
               accum_ff[e] <= '0;
            end
         end
      end else if (ctrl.acc_wr) begin
         accum_ff[ia] <= mac_result;
         ovf_ff[ia]   <= ovf_ff[ia] | mac_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.gam_wr) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.gam_wr) begin
         rsp_gamma_ff <= mac_result;
         rsp_power_ff <= ctrl.i;
         rsp_term_ff  <= ctrl.j;
         rsp_ovf_ff   <= mac_sat | ovf_ff[ia];
         rsp_last_ff  <= ctrl.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gamma_value = rsp_gamma_ff;
   assign rsp_power_index = rsp_power_ff;
   assign rsp_term_index  = rsp_term_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_term   = rsp_last_ff;

endmodule
